>>> sv/mfs_pkg.sv
// ----------------------------------------------------------------------------
// mfs_pkg
// Shared types, sizes and status codes of the maximum-frequency stack.
// ----------------------------------------------------------------------------
package mfs_pkg;

	// store size and value width
	localparam int CAPACITY   = 64;
	localparam int VALUE_BITS = 8;
	localparam int NUM_VALUES = 1 << VALUE_BITS;

	// a count never exceeds the number of stored entries
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// request codes
	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	// result status codes
	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_POP_EMPTY  = 2'd1;
	localparam logic [1:0] STATUS_PUSH_FULL  = 2'd2;

	// one stored entry
	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [CNT_W-1:0]      count;
	} entry_t;

	// broadcast control to every cell of the chain
	typedef struct packed {
		logic                  push;
		logic                  pop;
		logic [VALUE_BITS-1:0] value;
		logic [CNT_W-1:0]      count;
	} cell_ctl_t;

endpackage

>>> sv/mfs_ram.sv
// ----------------------------------------------------------------------------
// mfs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/mfs_cell.sv
// ----------------------------------------------------------------------------
// mfs_cell
// One position of the sorted entry chain. Holds one entry and on a push
// either keeps it, takes the new entry or takes its left neighbour; on a pop
// it takes its right neighbour.
// ----------------------------------------------------------------------------
module mfs_cell (
	input  logic               clk,
	input  mfs_pkg::cell_ctl_t ctl,
	input  logic               live,
	input  mfs_pkg::entry_t    left_entry,
	input  logic               left_gt,
	input  mfs_pkg::entry_t    right_entry,
	output mfs_pkg::entry_t    entry,
	output logic               gt
);
	import mfs_pkg::*;

	entry_t entry_q;

	// entry stays ahead of the new one only if its count is strictly higher
	assign gt = live && (entry_q.count > ctl.count);

	// insert or shift
	always_ff @(posedge clk) begin
		if (ctl.push && !gt) begin
			if (left_gt) begin
				entry_q <= '{value: ctl.value, count: ctl.count};
			end else begin
				entry_q <= left_entry;
			end
		end else if (ctl.pop) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;

endmodule

>>> sv/max_frequency_stack.sv
// ----------------------------------------------------------------------------
// max_frequency_stack
// Push/pop stack that always pops the most frequent value, most recent first.
// ----------------------------------------------------------------------------
// Each transaction has a read step and an update step: the read step reads the
// value's occurrence count from the 256-entry count RAM, the update step writes
// the updated count and shifts the chain of entry cells by one place. A new
// request is taken only while idle and the response side keeps up. Entries live in a
// chain of CAPACITY cells kept sorted by count, most recent first within a
// count, so the entry to pop is always in the first cell. Count RAM entries
// read as zero until first written (one flag per value cleared at reset), so
// no clearing pass is needed after reset. A push into a full store is dropped
// with status 2, a pop of an empty store returns zero with status 1.
module max_frequency_stack (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic                           req_type,
	input  logic [mfs_pkg::VALUE_BITS-1:0] push_value,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [mfs_pkg::VALUE_BITS-1:0] popped_value,
	output logic [1:0]                     status,
	output logic [mfs_pkg::CNT_W-1:0]      occupancy
);
	import mfs_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_UPD  = 1'b1;

	logic                  state_q;
	logic                  req_type_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [CNT_W-1:0]      occ_q;
	logic [NUM_VALUES-1:0] tbl_vld_q;
	logic                  rsp_valid_q;
	logic [VALUE_BITS-1:0] popped_value_q;
	logic [1:0]            status_q;
	logic [CNT_W-1:0]      occupancy_q;

	logic                  accept;
	logic                  upd;
	logic [VALUE_BITS-1:0] rd_addr;
	logic [CNT_W-1:0]      ram_rdata;
	logic [CNT_W-1:0]      tbl_cnt;
	logic [CNT_W-1:0]      new_cnt;
	logic                  full;
	logic                  empty;
	logic                  push_ok;
	logic                  pop_ok;
	cell_ctl_t             ctl;
	entry_t                cell_entry [CAPACITY];
	logic [CAPACITY-1:0]   cell_gt;
	logic [CAPACITY-1:0]   live;

	// request handshake: idle and the response register free by next edge
	assign req_stall = !((state_q == ST_IDLE) && (!rsp_valid_q || !rsp_stall));
	assign accept    = req_valid && !req_stall;
	assign upd       = (state_q == ST_UPD);

	// pop reads the count of the head value, push that of the pushed value
	assign rd_addr = (req_type == REQ_POP) ? cell_entry[0].value : push_value;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else if (accept) begin
			state_q <= ST_UPD;
		end else if (upd) begin
			state_q <= ST_IDLE;
		end
	end

	// captured transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q <= req_type;
			value_q    <= rd_addr;
		end
	end

	// occurrence count table
	mfs_ram #(
		.WIDTH (CNT_W),
		.DEPTH (NUM_VALUES)
	) u_tbl (
		.clk   (clk),
		.we    (upd && (push_ok || pop_ok)),
		.waddr (value_q),
		.wdata (new_cnt),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// unwritten table entries read as zero
	assign tbl_cnt = tbl_vld_q[value_q] ? ram_rdata : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_vld_q <= '0;
		end else if (upd && (push_ok || pop_ok)) begin
			tbl_vld_q[value_q] <= 1'b1;
		end
	end

	// update decision
	assign full    = (occ_q == CNT_W'(CAPACITY));
	assign empty   = (occ_q == '0);
	assign push_ok = (req_type_q == REQ_PUSH) && !full;
	assign pop_ok  = (req_type_q == REQ_POP) && !empty;

	always_comb begin
		if (req_type_q == REQ_PUSH) begin
			new_cnt = tbl_cnt + CNT_W'(1);
		end else if (tbl_cnt != '0) begin
			new_cnt = tbl_cnt - CNT_W'(1);
		end else begin
			new_cnt = '0;
		end
	end

	// chain control broadcast
	assign ctl.push  = upd && push_ok;
	assign ctl.pop   = upd && pop_ok;
	assign ctl.value = value_q;
	assign ctl.count = tbl_cnt + CNT_W'(1);

	// entry chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_g;

		assign live[i] = (CNT_W'(i) < occ_q);

		if (i == 0) begin : g_first
			assign left_e = cell_entry[0];
			assign left_g = 1'b1;
		end else begin : g_mid
			assign left_e = cell_entry[i-1];
			assign left_g = cell_gt[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_e = cell_entry[i];
		end else begin : g_inner
			assign right_e = cell_entry[i+1];
		end

		mfs_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.live        (live[i]),
			.left_entry  (left_e),
			.left_gt     (left_g),
			.right_entry (right_e),
			.entry       (cell_entry[i]),
			.gt          (cell_gt[i])
		);
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (upd && push_ok) begin
			occ_q <= occ_q + CNT_W'(1);
		end else if (upd && pop_ok) begin
			occ_q <= occ_q - CNT_W'(1);
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (upd) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			popped_value_q <= pop_ok ? value_q : '0;
			if (req_type_q == REQ_PUSH) begin
				status_q    <= full ? STATUS_PUSH_FULL : STATUS_OK;
				occupancy_q <= full ? occ_q : occ_q + CNT_W'(1);
			end else begin
				status_q    <= empty ? STATUS_POP_EMPTY : STATUS_OK;
				occupancy_q <= empty ? occ_q : occ_q - CNT_W'(1);
			end
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign popped_value = popped_value_q;
	assign status       = status_q;
	assign occupancy    = occupancy_q;

`ifndef SYNTH
	// store never holds more than its capacity
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	// every accepted transaction yields a registered response once its update state has run
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 rsp_valid_q)
		else $error("no response after accepted transaction");

	// the head entry's value always has a nonzero occurrence count
	a_head_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && pop_ok) |-> (tbl_cnt != '0))
		else $error("popped value has zero occurrence count");

	// reported occupancy tracks the entry count while a response is held
	a_occ_match: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (occupancy_q == occ_q))
		else $error("reported occupancy out of step with entry count");
`endif

endmodule
